// ===== hdl/piecewise_linear_interpolator_assert.svh =====
// Assertion macros for the piecewise linear interpolator checker.
// Needs no other file; the checker module includes it.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLI_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("piecewise linear interpolator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PLI_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("piecewise linear interpolator assertion failed");

`endif

// ===== hdl/pli_pkg.sv =====
// Package for the piecewise linear interpolator: widths, codes and payload types.
// Has no dependencies; pli_div, the top level and the checker import it.
`default_nettype none

package pli_pkg;

   localparam int VALUE_WIDTH         = 32;
   localparam int TABLE_DEPTH_DEFAULT = 256;
   localparam int ENTRY_INDEX_WIDTH   = 8;
   localparam int POINTS_WIDTH        = 9;

   localparam logic [POINTS_WIDTH-1:0] POINTS_RESET = POINTS_WIDTH'(2);
   localparam logic [POINTS_WIDTH-1:0] MIN_POINTS   = POINTS_WIDTH'(2);

   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   typedef enum logic [0:0] {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      CLAMP_NONE  = 2'd0,
      CLAMP_BELOW = 2'd1,
      CLAMP_ABOVE = 2'd2
   } clamp_type;

   typedef struct packed {
      op_type                         operation;
      logic [ENTRY_INDEX_WIDTH-1:0]   entry_index;
      logic signed [VALUE_WIDTH-1:0]  entry_x;
      logic signed [VALUE_WIDTH-1:0]  entry_y;
      logic signed [VALUE_WIDTH-1:0]  query_x;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0]  result_y;
      logic [ENTRY_INDEX_WIDTH-1:0]   interval_index;
      clamp_type                      clamp_code;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ===== hdl/pli_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Has no dependencies; used for the breakpoint tables.
`default_nettype none

module pli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== hdl/pli_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on pli_pkg for the value width.
`default_nettype none

module pli_div
   import pli_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [2*VALUE_WIDTH-1:0]   dividend,
   input  wire logic [VALUE_WIDTH-1:0]     divisor,
   output logic                            done,
   output logic [VALUE_WIDTH-1:0]          quotient
);

   localparam int COUNT_W = $clog2(VALUE_WIDTH);
   localparam logic [COUNT_W-1:0] LAST_STEP = COUNT_W'(VALUE_WIDTH - 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] quot_ff, quot_in;
   logic [VALUE_WIDTH:0]   trial;
   logic [VALUE_WIDTH:0]   diff;
   logic                   fits;

   // The upper half of the dividend is below the divisor, so the quotient
   // fits in one value width.
   assign trial = {rem_ff, quot_ff[VALUE_WIDTH-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = ~diff[VALUE_WIDTH];

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = dividend[2*VALUE_WIDTH-1:VALUE_WIDTH];
         quot_in  = dividend[VALUE_WIDTH-1:0];
      end else if (busy_ff) begin
         rem_in   = fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
         quot_in  = {quot_ff[VALUE_WIDTH-2:0], fits};
         count_in = count_ff + COUNT_W'(1);
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

// ===== hdl/piecewise_linear_interpolator.sv =====
// Top level of the piecewise linear interpolator: sequencer, breakpoint tables,
// multiplier and saturation. Depends on pli_pkg, pli_ram and pli_div.
//
//   Channel   Direction  Ports                          Moves
//   req       in         req_valid/req_stall/req_payload  load or query request
//   rsp       out        rsp_valid/rsp_stall/rsp_payload  one result per query
//   csr       in         csr_write_enable/csr_write_data  points_in_use register
//
// A load request leaves the sequencer idle, so the block is ready again in the
// next cycle. A query clamped below the first point ends after the first-point
// compare and one clamped above the last point after the last-point compare.
// An interior query runs a binary search that presents the midpoint read in
// S_MID and compares it in S_PROBE, then reads both interval ends, multiplies
// and waits on the iterative one-bit-per-cycle divider.
// Reset clears the sequencer, the result valid and points_in_use (to 2); the
// tables hold whatever was last written. A finished result waits in the
// output register while further requests are taken; only the next query's
// final step waits on a stalled result.
`default_nettype none

module piecewise_linear_interpolator
   import pli_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire req_payload_type         req_payload,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output rsp_payload_type              rsp_payload,
   input  wire logic                    csr_write_enable,
   input  wire logic [POINTS_WIDTH-1:0] csr_write_data
);

   localparam int IDX_W      = $clog2(TABLE_DEPTH);
   localparam int ENTRY_SPAN = 2 ** ENTRY_INDEX_WIDTH;
   localparam int SUM_W      = VALUE_WIDTH + 2;
   localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(VALUE_MAX);
   localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(VALUE_MIN);

   // The sequencer walks one query through the table reads, the search, the
   // multiply and the divide.
   typedef enum logic [3:0] {
      S_IDLE,
      S_FIRST,
      S_LAST,
      S_MID,
      S_PROBE,
      S_X0,
      S_X1,
      S_MUL,
      S_START,
      S_DIV,
      S_SUM,
      S_PUT
   } state_type;

   state_type                       state_ff, state_in;
   logic [POINTS_WIDTH-1:0]         points_in_use_ff, points_in_use_in;
   logic signed [VALUE_WIDTH-1:0]   query_ff, query_in;
   logic [IDX_W-1:0]                lo_ff, lo_in;
   logic [IDX_W-1:0]                hi_ff, hi_in;
   logic [IDX_W-1:0]                mid_ff, mid_in;
   logic signed [VALUE_WIDTH-1:0]   x0_ff, x0_in;
   logic signed [VALUE_WIDTH-1:0]   y0_ff, y0_in;
   logic [VALUE_WIDTH-1:0]          dxm_ff, dxm_in;
   logic [VALUE_WIDTH-1:0]          dym_ff, dym_in;
   logic [VALUE_WIDTH-1:0]          dtm_ff, dtm_in;
   logic                            neg_ff, neg_in;
   logic [2*VALUE_WIDTH-1:0]        product_ff, product_in;
   logic signed [VALUE_WIDTH-1:0]   res_y_ff, res_y_in;
   logic [IDX_W-1:0]                res_idx_ff, res_idx_in;
   clamp_type                       res_code_ff, res_code_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type                 rsp_payload_ff, rsp_payload_in;

   logic                            req_accept;
   logic [IDX_W-1:0]                last_index;
   logic [IDX_W-1:0]                span;
   logic [IDX_W-1:0]                rd_addr;
   logic [IDX_W-1:0]                wr_addr;
   logic                            wr_en;
   logic signed [VALUE_WIDTH-1:0]   x_rd;
   logic signed [VALUE_WIDTH-1:0]   y_rd;
   logic                            div_start;
   logic                            div_done;
   logic [VALUE_WIDTH-1:0]          div_quotient;
   logic signed [SUM_W-1:0]         y0_wide;
   logic signed [SUM_W-1:0]         q_wide;
   logic signed [SUM_W-1:0]         sum_value;
   logic [IDX_W-1:0]                pos_table [ENTRY_SPAN];

   assign req_accept = req_valid & ~req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Load positions wrap at the table depth. The table is worked out at
   // elaboration, so no divider is built.
   for (genvar g = 0; g < ENTRY_SPAN; g++) begin : g_pos
      assign pos_table[g] = IDX_W'(g % TABLE_DEPTH);
   end

   assign wr_en   = req_accept && (req_payload.operation == OP_LOAD);
   assign wr_addr = pos_table[req_payload.entry_index];

   // The point count is clamped to the range the table can hold.
   always_comb begin
      if (points_in_use_ff < MIN_POINTS) begin
         last_index = IDX_W'(1);
      end else if (int'(points_in_use_ff) > TABLE_DEPTH) begin
         last_index = IDX_W'(TABLE_DEPTH - 1);
      end else begin
         last_index = IDX_W'(points_in_use_ff - POINTS_WIDTH'(1));
      end
   end

   assign points_in_use_in = csr_write_enable ? csr_write_data : points_in_use_ff;

   assign span = hi_ff - lo_ff;

   // The final offset is added with its sign and then saturated. The
   // quotient stays below 2**VALUE_WIDTH, so two guard bits are enough.
   assign y0_wide   = SUM_W'(y0_ff);
   assign q_wide    = signed'({2'b00, div_quotient});
   assign sum_value = neg_ff ? (y0_wide - q_wide) : (y0_wide + q_wide);

   pli_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_x_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_payload.entry_x),
      .rd_addr (rd_addr),
      .rd_data (x_rd)
   );

   pli_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_y_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_payload.entry_y),
      .rd_addr (rd_addr),
      .rd_data (y_rd)
   );

   pli_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product_ff),
      .divisor  (dxm_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // The read address is presented in the state before the one that uses the
   // data, since the tables register their read.
   always_comb begin
      state_in       = state_ff;
      query_in       = query_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      mid_in         = mid_ff;
      x0_in          = x0_ff;
      y0_in          = y0_ff;
      dxm_in         = dxm_ff;
      dym_in         = dym_ff;
      dtm_in         = dtm_ff;
      neg_in         = neg_ff;
      product_in     = product_ff;
      res_y_in       = res_y_ff;
      res_idx_in     = res_idx_ff;
      res_code_in    = res_code_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      rd_addr        = lo_ff;
      div_start      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            rd_addr = '0;
            if (req_accept && (req_payload.operation == OP_QUERY)) begin
               query_in = req_payload.query_x;
               lo_in    = '0;
               hi_in    = last_index;
               state_in = S_FIRST;
            end
         end
         S_FIRST: begin
            // First point is on the read port; fetch the last one next.
            rd_addr = hi_ff;
            if (query_ff <= x_rd) begin
               res_y_in    = y_rd;
               res_idx_in  = '0;
               res_code_in = CLAMP_BELOW;
               state_in    = S_PUT;
            end else begin
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            if (query_ff >= x_rd) begin
               res_y_in    = y_rd;
               res_idx_in  = hi_ff;
               res_code_in = CLAMP_ABOVE;
               state_in    = S_PUT;
            end else begin
               state_in = S_MID;
            end
         end
         S_MID: begin
            // Invariant: x[lo] < query <= x[hi].
            mid_in = lo_ff + (span >> 1);
            if (span == IDX_W'(1)) begin
               rd_addr  = lo_ff;
               state_in = S_X0;
            end else begin
               rd_addr  = mid_in;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (query_ff <= x_rd) begin
               if ((mid_ff - lo_ff) == IDX_W'(1)) begin
                  rd_addr  = lo_ff;
                  state_in = S_X0;
               end else begin
                  hi_in    = mid_ff;
                  state_in = S_MID;
               end
            end else begin
               lo_in    = mid_ff;
               state_in = S_MID;
            end
         end
         S_X0: begin
            x0_in    = x_rd;
            y0_in    = y_rd;
            rd_addr  = lo_ff + IDX_W'(1);
            state_in = S_X1;
         end
         S_X1: begin
            res_idx_in  = lo_ff;
            res_code_in = CLAMP_NONE;
            if (x_rd <= x0_ff) begin
               // An interval that does not rise gives its lower y.
               res_y_in = y0_ff;
               state_in = S_PUT;
            end else begin
               // Magnitudes are below 2**VALUE_WIDTH, so the wrapped
               // difference holds them exactly.
               dxm_in = x_rd - x0_ff;
               dym_in = (y_rd >= y0_ff) ? (y_rd - y0_ff) : (y0_ff - y_rd);
               dtm_in = (query_ff >= x0_ff) ? (query_ff - x0_ff) : (x0_ff - query_ff);
               neg_in = (y_rd < y0_ff) != (query_ff < x0_ff);
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            product_in = dym_ff * dtm_ff;
            state_in   = S_START;
         end
         S_START: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            if (sum_value > SUM_MAX) begin
               res_y_in = VALUE_MAX;
            end else if (sum_value < SUM_MIN) begin
               res_y_in = VALUE_MIN;
            end else begin
               res_y_in = VALUE_WIDTH'(sum_value);
            end
            state_in = S_PUT;
         end
         S_PUT: begin
            // Hand the result over once the output register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                  = 1'b1;
               rsp_payload_in.result_y       = res_y_ff;
               rsp_payload_in.interval_index = ENTRY_INDEX_WIDTH'(res_idx_ff);
               rsp_payload_in.clamp_code     = res_code_ff;
               state_in                      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         rsp_valid_ff     <= 1'b0;
         points_in_use_ff <= POINTS_RESET;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         points_in_use_ff <= points_in_use_in;
      end
      query_ff       <= query_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      mid_ff         <= mid_in;
      x0_ff          <= x0_in;
      y0_ff          <= y0_in;
      dxm_ff         <= dxm_in;
      dym_ff         <= dym_in;
      dtm_ff         <= dtm_in;
      neg_ff         <= neg_in;
      product_ff     <= product_in;
      res_y_ff       <= res_y_in;
      res_idx_ff     <= res_idx_in;
      res_code_ff    <= res_code_in;
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

`default_nettype wire

// ===== hdl/pli_checker.sv =====
// Port-level assertions for the piecewise linear interpolator, bound to the top.
// Depends on pli_pkg and piecewise_linear_interpolator_assert.svh.
`default_nettype none

`include "piecewise_linear_interpolator_assert.svh"

module pli_checker
   import pli_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_valid,
   input wire logic            req_stall,
   input wire req_payload_type req_payload,
   input wire logic            rsp_valid,
   input wire logic            rsp_stall,
   input wire rsp_payload_type rsp_payload
);

   // A result that is held back stays put until taken.
   `PLI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

   // A query keeps the block busy for at least the following cycle.
   `PLI_ASSERT_NEXT(a_query_busy, clock, reset, req_valid && !req_stall && (req_payload.operation == OP_QUERY), req_stall)

   // A load leaves the block ready in the next cycle.
   `PLI_ASSERT_NEXT(a_load_done, clock, reset, req_valid && !req_stall && (req_payload.operation == OP_LOAD), !req_stall)

   // Clamping below always reports the first interval.
   `PLI_ASSERT_SAME(a_below_index, clock, reset, rsp_valid && (rsp_payload.clamp_code == CLAMP_BELOW), rsp_payload.interval_index == '0)

endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (.*);

`default_nettype wire
